[rtl/piq_pkg.sv]
package piq_pkg;

   // Default sizing
   localparam int DEPTH_DEF      = 16;
   localparam int DATA_WIDTH_DEF = 32;

   // Fixed field widths of the request and response
   localparam int FUNC_W     = 2;
   localparam int DATA_PORT_W = 32;
   localparam int POS_W      = 5;
   localparam int STATUS_W   = 2;
   localparam int COUNT_W    = 5;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_APPEND     = 2'd0,
      FUNC_INSERT     = 2'd1,
      FUNC_REMOVE_HEAD = 2'd2,
      FUNC_REMOVE_TAIL = 2'd3
   } piq_func_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } piq_status_type;

   typedef struct packed {
      piq_func_type             func;
      logic [DATA_PORT_W-1:0]   data;
      logic [POS_W-1:0]         position;
   } piq_req_type;

   typedef struct packed {
      piq_status_type           status;
      logic [DATA_PORT_W-1:0]   removed_data;
      logic [COUNT_W-1:0]       item_count;
   } piq_rsp_type;

   // Per-cycle command broadcast to every cell
   typedef struct packed {
      logic insert;   // open a gap at the insert index and load the new word
      logic pull;     // every cell takes its right neighbor (head removal)
   } piq_cell_ctrl_type;

endpackage

[rtl/piq_cell.sv]
module piq_cell #(
   parameter int DATA_WIDTH = piq_pkg::DATA_WIDTH_DEF,
   parameter int IDX_W      = $clog2(piq_pkg::DEPTH_DEF),
   parameter int INDEX      = 0
) (
   input  logic                        clock,
   input  piq_pkg::piq_cell_ctrl_type  ctrl,
   input  logic [IDX_W-1:0]            ins_idx,
   input  logic [DATA_WIDTH-1:0]       new_word,
   input  logic [DATA_WIDTH-1:0]       prev_word,
   input  logic [DATA_WIDTH-1:0]       next_word,
   output logic [DATA_WIDTH-1:0]       word_out
);
   import piq_pkg::*;

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

   logic [DATA_WIDTH-1:0] data_ff;
   logic [DATA_WIDTH-1:0] data_in;

   // Select: load at the gap, shift back behind it, or pull from the right
   always_comb begin
      priority if (ctrl.insert && (MY_IDX == ins_idx)) begin
         data_in = new_word;
      end else if (ctrl.insert && (MY_IDX > ins_idx)) begin
         data_in = prev_word;
      end else if (ctrl.pull) begin
         data_in = next_word;
      end else begin
         data_in = data_ff;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign word_out = data_ff;

endmodule

[rtl/positional_insert_queue_unit.sv]
// Positional-insert queue: a row of word cells, element 1 in cell 0.
// The response is registered and appears in the cycle after the request is accepted.
// Throughput: one request per cycle while the response register is free or being drained; cells update on accept.
// Reset clears the word count and the response valid; cell contents are not reset
// and only cells below the count are ever read.
module positional_insert_queue_unit #(
   parameter int DEPTH      = piq_pkg::DEPTH_DEF,
   parameter int DATA_WIDTH = piq_pkg::DATA_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  piq_pkg::piq_req_type  req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output piq_pkg::piq_rsp_type  rsp_payload
);
   import piq_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   logic [CNT_W-1:0]      occ_ff;
   logic [CNT_W-1:0]      occ_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   piq_rsp_type           rsp_payload_ff;
   piq_rsp_type           rsp_payload_in;

   logic                  req_fire;
   logic                  full;
   logic                  empty;
   logic [CMP_W-1:0]      pos_ext;
   logic [CMP_W-1:0]      occ_ext;
   logic [IDX_W-1:0]      tail_idx;
   logic [IDX_W-1:0]      ins_idx;
   piq_cell_ctrl_type     ctrl;
   piq_status_type        status;
   logic [DATA_WIDTH-1:0] removed;
   logic [DATA_WIDTH-1:0] new_word;
   logic [DATA_PORT_W-1:0] removed_out;
   logic [DATA_WIDTH-1:0] cell_data [DEPTH];

   // Accept whenever the response register is free or being drained
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   assign full     = (occ_ff == CNT_W'(DEPTH));
   assign empty    = (occ_ff == '0);
   assign pos_ext  = CMP_W'(req_payload.position);
   assign occ_ext  = CMP_W'(occ_ff);
   assign tail_idx = IDX_W'(occ_ff - CNT_W'(1));

   // Fit the request word to the stored width and the stored word to the port
   generate
      if (DATA_WIDTH >= DATA_PORT_W) begin : g_wide
         assign new_word    = DATA_WIDTH'(req_payload.data);
         assign removed_out = removed[DATA_PORT_W-1:0];
      end else begin : g_narrow
         assign new_word    = req_payload.data[DATA_WIDTH-1:0];
         assign removed_out = DATA_PORT_W'(removed);
      end
   endgenerate

   // Decode the request into a cell command, status and next count
   always_comb begin
      ctrl    = '0;
      ins_idx = '0;
      occ_in  = occ_ff;
      status  = ST_DONE;
      removed = '0;
      unique case (req_payload.func)
         FUNC_APPEND, FUNC_INSERT: begin
            if (full) begin
               status = ST_FULL;
            end else begin
               ctrl.insert = req_fire;
               occ_in      = occ_ff + CNT_W'(1);
               priority if (req_payload.func == FUNC_APPEND || pos_ext > occ_ext) begin
                  ins_idx = IDX_W'(occ_ff);
               end else if (pos_ext < CMP_W'(2)) begin
                  ins_idx = '0;
               end else begin
                  ins_idx = IDX_W'(pos_ext - CMP_W'(1));
               end
            end
         end
         FUNC_REMOVE_HEAD: begin
            if (empty) begin
               status = ST_EMPTY;
            end else begin
               removed   = cell_data[0];
               ctrl.pull = req_fire;
               occ_in    = occ_ff - CNT_W'(1);
            end
         end
         FUNC_REMOVE_TAIL: begin
            if (empty) begin
               status = ST_EMPTY;
            end else begin
               removed = cell_data[tail_idx];
               occ_in  = occ_ff - CNT_W'(1);
            end
         end
         default: begin
            status = ST_DONE;
         end
      endcase
   end

   // Row of cells, each wired to its neighbors
   generate
      for (genvar i = 0; i < DEPTH; i++) begin : g_cell
         logic [DATA_WIDTH-1:0] prev_w;
         logic [DATA_WIDTH-1:0] next_w;
         if (i == 0) begin : g_first
            assign prev_w = '0;
         end else begin : g_mid_prev
            assign prev_w = cell_data[i-1];
         end
         if (i == DEPTH - 1) begin : g_last
            assign next_w = '0;
         end else begin : g_mid_next
            assign next_w = cell_data[i+1];
         end
         piq_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .IDX_W      (IDX_W),
            .INDEX      (i)
         ) u_cell (
            .clock     (clock),
            .ctrl      (ctrl),
            .ins_idx   (ins_idx),
            .new_word  (new_word),
            .prev_word (prev_w),
            .next_word (next_w),
            .word_out  (cell_data[i])
         );
      end
   endgenerate

   // Response register: load on accept, drop on drain
   always_comb begin
      rsp_payload_in              = rsp_payload_ff;
      rsp_valid_in                = rsp_valid_ff;
      if (req_fire) begin
         rsp_valid_in                = 1'b1;
         rsp_payload_in.status       = status;
         rsp_payload_in.removed_data = removed_out;
         rsp_payload_in.item_count   = COUNT_W'(occ_in);
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_fire) begin
            occ_ff <= occ_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

`ifndef SYNTHESIS
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= CNT_W'(DEPTH))
      else $error("word count above depth");

   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_valid_ff)
      else $error("accepted request produced no response");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_payload_ff.status == ST_FULL) |-> full)
      else $error("full status while queue not full");

   a_empty_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_payload_ff.status == ST_EMPTY) |-> empty)
      else $error("empty status while queue holds words");

   a_put_grows: assert property (@(posedge clock) disable iff (reset)
      (req_fire && !full &&
       (req_payload.func == FUNC_APPEND || req_payload.func == FUNC_INSERT))
      |=> (occ_ff == $past(occ_ff) + CNT_W'(1)))
      else $error("insert did not grow the count");
`endif

endmodule
